// ===== hw/rtl/char_lcd_terminal_writer_top_assert.svh =====
// Assertion macros used by the terminal writer checker.
`ifndef CHAR_LCD_TERMINAL_WRITER_TOP_ASSERT_SVH
`define CHAR_LCD_TERMINAL_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cltw check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cltw check failed");

`endif

// ===== hw/rtl/cltw_pkg.sv =====
// Shared types, constants and command/status structs of the LCD terminal writer.
`default_nettype none

package cltw_pkg;

    // Geometry and escape buffer sizing
    localparam int ESC_BUF_DEPTH = 4;
    localparam int MAX_COLUMNS   = 40;
    localparam int MAX_ROWS      = 4;
    localparam int ESC_LEN_W     = $clog2(ESC_BUF_DEPTH + 1);
    localparam int ESC_IDX_W     = $clog2(ESC_BUF_DEPTH);

    // A sequence can only match if it is shorter than the buffer
    localparam bit SEQ_CLEAR_OK  = (ESC_BUF_DEPTH > 3);
    localparam bit SEQ_HOME_OK   = (ESC_BUF_DEPTH > 2);

    // Character codes
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    // Display controller instructions
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] CMD_ADDR  = 8'h80;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_START = 3'd5;

    // Register reset values
    localparam logic [5:0] COLUMNS_RST   = 6'd16;
    localparam logic [2:0] ROW_COUNT_RST = 3'd2;
    localparam logic [6:0] ROW0_RST      = 7'h00;
    localparam logic [6:0] ROW1_RST      = 7'h40;
    localparam logic [6:0] ROW2_RST      = 7'h14;
    localparam logic [6:0] ROW3_RST      = 7'h54;

    // Channel words
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_in_word;

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
        logic [5:0] repeat_res;
        logic       last;
    } t_out_word;

    // Which write the datapath forms
    typedef enum logic [2:0] {
        EM_DATA,
        EM_ROW_ADDR,
        EM_CLEAR,
        EM_HOME,
        EM_CLR_ADDR,
        EM_SPACES
    } t_emit_sel;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_WRAP,
        ST_CLR_ADDR,
        ST_NL1,
        ST_NL2,
        ST_NL3,
        ST_NL4,
        ST_NEXT,
        ST_FINAL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic      load_in;
        logic      load_replay;
        logic      cur_esc;
        logic      emit;
        t_emit_sel emit_sel;
        logic      final_push;
        logic      put_adv;
        logic      row_next;
        logic      col_zero;
        logic      home;
        logic      esc_enter;
        logic      esc_append;
        logic      esc_leave;
        logic      rp_load;
        logic      rp_with_cur;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_escape;
        logic ch_cr;
        logic ch_lf;
        logic ch_esc;
        logic match_clear;
        logic match_home;
        logic esc_fill;
        logic put_wrap;
        logic replay_more;
        logic slot_ok;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/cltw_ctrl.sv =====
// Sequencer that walks one character at a time through its display writes.
`default_nettype none

module cltw_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_in_kind,
    input  cltw_pkg::t_dp_status   i_status,
    output cltw_pkg::t_dp_cmd      o_cmd
);

    cltw_pkg::t_state r_state, n_state;
    logic             r_flush_mode, n_flush_mode;

    // State and flush flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cltw_pkg::ST_IDLE;
            r_flush_mode <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_flush_mode <= n_flush_mode;
        end
    end

    // Next state
    always_comb begin
        n_state      = r_state;
        n_flush_mode = r_flush_mode;
        case (r_state)
            cltw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_flush_mode = i_in_kind;
                    n_state      = i_in_kind ? cltw_pkg::ST_NEXT : cltw_pkg::ST_DECODE;
                end
            end
            cltw_pkg::ST_DECODE: begin
                if (i_status.in_escape) begin
                    if (i_status.match_clear) begin
                        if (i_status.slot_ok) n_state = cltw_pkg::ST_CLR_ADDR;
                    end else if (i_status.match_home) begin
                        if (i_status.slot_ok) n_state = cltw_pkg::ST_NEXT;
                    end else if (i_status.esc_fill) begin
                        n_state = cltw_pkg::ST_PUT;
                    end else begin
                        n_state = cltw_pkg::ST_NEXT;
                    end
                end else if (i_status.ch_cr) begin
                    if (i_status.slot_ok) n_state = cltw_pkg::ST_NEXT;
                end else if (i_status.ch_lf) begin
                    n_state = cltw_pkg::ST_NL1;
                end else if (i_status.ch_esc) begin
                    n_state = cltw_pkg::ST_NEXT;
                end else begin
                    n_state = cltw_pkg::ST_PUT;
                end
            end
            cltw_pkg::ST_PUT: begin
                if (i_status.slot_ok) begin
                    n_state = i_status.put_wrap ? cltw_pkg::ST_WRAP : cltw_pkg::ST_NEXT;
                end
            end
            cltw_pkg::ST_WRAP: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_NEXT;
            end
            cltw_pkg::ST_CLR_ADDR: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_NEXT;
            end
            cltw_pkg::ST_NL1: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_NL2;
            end
            cltw_pkg::ST_NL2: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_NL3;
            end
            cltw_pkg::ST_NL3: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_NL4;
            end
            cltw_pkg::ST_NL4: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_NEXT;
            end
            cltw_pkg::ST_NEXT: begin
                if (i_status.replay_more) begin
                    n_state = cltw_pkg::ST_DECODE;
                end else if (r_flush_mode && i_status.in_escape) begin
                    n_state = cltw_pkg::ST_PUT;
                end else begin
                    n_state = cltw_pkg::ST_FINAL;
                end
            end
            cltw_pkg::ST_FINAL: begin
                if (i_status.slot_ok) n_state = cltw_pkg::ST_IDLE;
            end
            default: begin
                n_state = cltw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.emit_sel = cltw_pkg::EM_DATA;
        o_in_ready     = 1'b0;
        case (r_state)
            cltw_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            cltw_pkg::ST_DECODE: begin
                if (i_status.in_escape) begin
                    if (i_status.match_clear) begin
                        o_cmd.emit     = i_status.slot_ok;
                        o_cmd.emit_sel = cltw_pkg::EM_CLEAR;
                    end else if (i_status.match_home) begin
                        o_cmd.emit      = i_status.slot_ok;
                        o_cmd.emit_sel  = cltw_pkg::EM_HOME;
                        o_cmd.home      = i_status.slot_ok;
                        o_cmd.esc_leave = i_status.slot_ok;
                    end else if (i_status.esc_fill) begin
                        // full without a match: replay ESC and the buffer as text
                        o_cmd.rp_load     = 1'b1;
                        o_cmd.rp_with_cur = 1'b1;
                        o_cmd.esc_leave   = 1'b1;
                        o_cmd.cur_esc     = 1'b1;
                    end else begin
                        o_cmd.esc_append = 1'b1;
                    end
                end else if (i_status.ch_cr) begin
                    o_cmd.emit     = i_status.slot_ok;
                    o_cmd.emit_sel = cltw_pkg::EM_ROW_ADDR;
                    o_cmd.col_zero = i_status.slot_ok;
                end else if (i_status.ch_lf) begin
                    o_cmd.row_next = 1'b1;
                end else if (i_status.ch_esc) begin
                    o_cmd.esc_enter = 1'b1;
                end
            end
            cltw_pkg::ST_PUT: begin
                o_cmd.emit     = i_status.slot_ok;
                o_cmd.emit_sel = cltw_pkg::EM_DATA;
                o_cmd.put_adv  = i_status.slot_ok;
            end
            cltw_pkg::ST_WRAP: begin
                o_cmd.emit     = i_status.slot_ok;
                o_cmd.emit_sel = cltw_pkg::EM_ROW_ADDR;
            end
            cltw_pkg::ST_CLR_ADDR: begin
                o_cmd.emit      = i_status.slot_ok;
                o_cmd.emit_sel  = cltw_pkg::EM_CLR_ADDR;
                o_cmd.esc_leave = i_status.slot_ok;
            end
            cltw_pkg::ST_NL1, cltw_pkg::ST_NL2, cltw_pkg::ST_NL4: begin
                o_cmd.emit     = i_status.slot_ok;
                o_cmd.emit_sel = cltw_pkg::EM_ROW_ADDR;
            end
            cltw_pkg::ST_NL3: begin
                o_cmd.emit     = i_status.slot_ok;
                o_cmd.emit_sel = cltw_pkg::EM_SPACES;
            end
            cltw_pkg::ST_NEXT: begin
                if (i_status.replay_more) begin
                    o_cmd.load_replay = 1'b1;
                end else if (r_flush_mode && i_status.in_escape) begin
                    o_cmd.rp_load   = 1'b1;
                    o_cmd.esc_leave = 1'b1;
                    o_cmd.cur_esc   = 1'b1;
                end
            end
            cltw_pkg::ST_FINAL: begin
                o_cmd.final_push = i_status.slot_ok;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cltw_datapath.sv =====
// Datapath: config registers, cursor, escape and replay buffers, output words.
`default_nettype none

module cltw_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cltw_pkg::t_dp_cmd                 i_cmd,
    output cltw_pkg::t_dp_status              o_status,
    input  logic [7:0]                        i_in_ch,
    input  logic                              i_cfg_valid,
    input  logic [cltw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cltw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cltw_pkg::t_out_word               o_out_word
);

    // Configuration
    logic [5:0] r_columns;
    logic [2:0] r_row_count;
    logic [6:0] r_row_start [4];

    // Cursor and current character
    logic [1:0] r_row;
    logic [5:0] r_col;
    logic [7:0] r_cur_ch;

    // Escape buffer and replay copy
    logic                            r_in_esc;
    logic [cltw_pkg::ESC_LEN_W-1:0]  r_esc_len;
    logic [7:0]                      r_esc_buf [cltw_pkg::ESC_BUF_DEPTH];
    logic [7:0]                      esc_view  [cltw_pkg::ESC_BUF_DEPTH];
    logic [cltw_pkg::ESC_LEN_W-1:0]  r_rp_len;
    logic [cltw_pkg::ESC_LEN_W-1:0]  r_rp_idx;
    logic [7:0]                      r_rp_buf  [cltw_pkg::ESC_BUF_DEPTH];

    // Output staging: pending word waits until its successor or item end is known
    logic                 r_pend_v;
    cltw_pkg::t_out_word  r_pend;
    cltw_pkg::t_out_word  pend_last;
    logic                 r_out_v;
    cltw_pkg::t_out_word  r_out;
    cltw_pkg::t_out_word  new_word;

    logic [5:0] cols_used;
    logic [2:0] rows_used;
    logic [2:0] row_inc;
    logic [1:0] next_row;
    logic [5:0] col_p1;
    logic       put_wrap;
    logic [6:0] row_base;
    logic [7:0] addr_sum;
    logic       slot_ok;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns      <= cltw_pkg::COLUMNS_RST;
            r_row_count    <= cltw_pkg::ROW_COUNT_RST;
            r_row_start[0] <= cltw_pkg::ROW0_RST;
            r_row_start[1] <= cltw_pkg::ROW1_RST;
            r_row_start[2] <= cltw_pkg::ROW2_RST;
            r_row_start[3] <= cltw_pkg::ROW3_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cltw_pkg::REG_COLUMNS:    r_columns      <= i_cfg_data[5:0];
                cltw_pkg::REG_ROW_COUNT:  r_row_count    <= i_cfg_data[2:0];
                cltw_pkg::REG_ROW0_START: r_row_start[0] <= i_cfg_data[6:0];
                cltw_pkg::REG_ROW1_START: r_row_start[1] <= i_cfg_data[6:0];
                cltw_pkg::REG_ROW2_START: r_row_start[2] <= i_cfg_data[6:0];
                cltw_pkg::REG_ROW3_START: r_row_start[3] <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Clamped geometry
    always_comb begin
        if (r_columns == 6'd0) begin
            cols_used = 6'd1;
        end else if (r_columns > 6'(cltw_pkg::MAX_COLUMNS)) begin
            cols_used = 6'(cltw_pkg::MAX_COLUMNS);
        end else begin
            cols_used = r_columns;
        end
        if (r_row_count == 3'd0) begin
            rows_used = 3'd1;
        end else if (r_row_count > 3'(cltw_pkg::MAX_ROWS)) begin
            rows_used = 3'(cltw_pkg::MAX_ROWS);
        end else begin
            rows_used = r_row_count;
        end
    end

    // Next row modulo rows in use; row_inc is 1..4
    always_comb begin
        row_inc = {1'b0, r_row} + 3'd1;
        case (rows_used)
            3'd1:    next_row = 2'd0;
            3'd2:    next_row = {1'b0, row_inc[0]};
            3'd3:    next_row = (row_inc >= 3'd3) ? 2'(row_inc - 3'd3) : row_inc[1:0];
            default: next_row = row_inc[1:0];
        endcase
    end

    assign col_p1   = r_col + 6'd1;
    assign put_wrap = (col_p1 >= cols_used);
    assign row_base = r_row_start[r_row];
    assign addr_sum = {1'b0, row_base} + {2'b00, r_col};

    // Cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 2'd0;
            r_col <= 6'd0;
        end else if (i_cmd.home) begin
            r_row <= 2'd0;
            r_col <= 6'd0;
        end else if (i_cmd.row_next) begin
            r_row <= next_row;
            r_col <= 6'd0;
        end else if (i_cmd.put_adv) begin
            if (put_wrap) begin
                r_row <= next_row;
                r_col <= 6'd0;
            end else begin
                r_col <= col_p1;
            end
        end else if (i_cmd.col_zero) begin
            r_col <= 6'd0;
        end
    end

    // Buffer contents with the current character placed at the fill position
    always_comb begin
        for (int i = 0; i < cltw_pkg::ESC_BUF_DEPTH; i++) begin
            esc_view[i] = (r_esc_len == cltw_pkg::ESC_LEN_W'(i)) ? r_cur_ch : r_esc_buf[i];
        end
    end

    // Current character
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur_ch <= i_in_ch;
        end else if (i_cmd.load_replay) begin
            r_cur_ch <= r_rp_buf[r_rp_idx[cltw_pkg::ESC_IDX_W-1:0]];
        end else if (i_cmd.cur_esc) begin
            r_cur_ch <= cltw_pkg::CH_ESC;
        end
    end

    // Escape control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_esc  <= 1'b0;
            r_esc_len <= '0;
        end else if (i_cmd.esc_leave) begin
            r_in_esc  <= 1'b0;
            r_esc_len <= '0;
        end else begin
            if (i_cmd.esc_enter) r_in_esc <= 1'b1;
            if (i_cmd.esc_append) r_esc_len <= r_esc_len + 1'b1;
        end
    end

    // Escape buffer storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.esc_append &&
            (r_esc_len < cltw_pkg::ESC_LEN_W'(cltw_pkg::ESC_BUF_DEPTH))) begin
            r_esc_buf[r_esc_len[cltw_pkg::ESC_IDX_W-1:0]] <= r_cur_ch;
        end
    end

    // Replay control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_len <= '0;
            r_rp_idx <= '0;
        end else if (i_cmd.rp_load) begin
            r_rp_len <= i_cmd.rp_with_cur ? r_esc_len + 1'b1 : r_esc_len;
            r_rp_idx <= '0;
        end else if (i_cmd.load_replay) begin
            r_rp_idx <= r_rp_idx + 1'b1;
        end
    end

    // Replay copy storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.rp_load) begin
            for (int i = 0; i < cltw_pkg::ESC_BUF_DEPTH; i++) begin
                r_rp_buf[i] <= esc_view[i];
            end
        end
    end

    // Form the selected write
    always_comb begin
        new_word.is_data    = 1'b0;
        new_word.value      = cltw_pkg::CMD_ADDR | {1'b0, row_base};
        new_word.repeat_res = 6'd1;
        new_word.last       = 1'b0;
        case (i_cmd.emit_sel)
            cltw_pkg::EM_DATA: begin
                new_word.is_data = 1'b1;
                new_word.value   = r_cur_ch;
            end
            cltw_pkg::EM_ROW_ADDR: begin
                new_word.value = cltw_pkg::CMD_ADDR | {1'b0, row_base};
            end
            cltw_pkg::EM_CLEAR: begin
                new_word.value = cltw_pkg::CMD_CLEAR;
            end
            cltw_pkg::EM_HOME: begin
                new_word.value = cltw_pkg::CMD_HOME;
            end
            cltw_pkg::EM_CLR_ADDR: begin
                new_word.value = cltw_pkg::CMD_ADDR | {1'b0, addr_sum[6:0]};
            end
            cltw_pkg::EM_SPACES: begin
                new_word.is_data    = 1'b1;
                new_word.value      = cltw_pkg::CH_SPACE;
                new_word.repeat_res = cols_used;
            end
            default: begin
                new_word.value = cltw_pkg::CMD_ADDR | {1'b0, row_base};
            end
        endcase
    end

    // Pending word marked as the final write of its item
    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    // A new word may enter when the pending stage can move on
    assign slot_ok = !r_pend_v || !r_out_v || i_out_ready;

    // Output staging control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_out_ready) r_out_v <= 1'b0;
            if (i_cmd.emit) begin
                if (r_pend_v) r_out_v <= 1'b1;
                r_pend_v <= 1'b1;
            end else if (i_cmd.final_push && r_pend_v) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

    // Output staging payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_pend_v) r_out <= r_pend;
            r_pend <= new_word;
        end else if (i_cmd.final_push && r_pend_v) begin
            r_out <= pend_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    // Status to the sequencer
    always_comb begin
        o_status.in_escape   = r_in_esc;
        o_status.ch_cr       = (r_cur_ch == cltw_pkg::CH_CR);
        o_status.ch_lf       = (r_cur_ch == cltw_pkg::CH_LF);
        o_status.ch_esc      = (r_cur_ch == cltw_pkg::CH_ESC);
        o_status.match_clear = cltw_pkg::SEQ_CLEAR_OK
                               && (r_esc_len == cltw_pkg::ESC_LEN_W'(2))
                               && (r_esc_buf[0] == cltw_pkg::CH_LBRACKET)
                               && (r_esc_buf[1] == cltw_pkg::CH_TWO)
                               && (r_cur_ch == cltw_pkg::CH_J);
        o_status.match_home  = cltw_pkg::SEQ_HOME_OK
                               && (r_esc_len == cltw_pkg::ESC_LEN_W'(1))
                               && (r_esc_buf[0] == cltw_pkg::CH_LBRACKET)
                               && (r_cur_ch == cltw_pkg::CH_H);
        o_status.esc_fill    = (r_esc_len == cltw_pkg::ESC_LEN_W'(cltw_pkg::ESC_BUF_DEPTH - 1));
        o_status.put_wrap    = put_wrap;
        o_status.replay_more = (r_rp_idx != r_rp_len);
        o_status.slot_ok     = slot_ok;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_terminal_writer_top.sv =====
// Top level of the character LCD text terminal writer.
`default_nettype none

// Turns a stream of text characters into character-LCD data and instruction
// writes, tracking the cursor, wrapping rows, expanding newlines into an
// address/address/blank/address sequence and decoding the ESC [2J and ESC [H
// sequences; an unmatched full sequence or a flush word replays it as text.
// Items are taken one at a time: the sequencer decodes a character, spends a
// state on each write it produces, steps to the next character and closes the
// item; a replayed escape sequence is decoded again per buffered character.
// Output back-pressure stalls the sequencer, since each write must move through
// a single pending stage and the output register.
// Configuration is accepted every cycle and should only be written while idle.

module char_lcd_terminal_writer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cltw_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cltw_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cltw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cltw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cltw_pkg::t_dp_cmd    dp_cmd;
    cltw_pkg::t_dp_status dp_status;

    // Register writes never stall
    assign o_cfg_ready = 1'b1;

    cltw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_kind  (i_in_word.kind),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    cltw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_ch     (i_in_word.ch),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cltw_checker.sv =====
// Port-level checker for the terminal writer, bound to the top level.
`default_nettype none

`include "char_lcd_terminal_writer_top_assert.svh"

module cltw_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  cltw_pkg::t_out_word               o_out_word
);

    logic out_wait;
    logic out_rep;
    logic out_rep_ok;

    assign out_wait   = o_out_valid && !i_out_ready;
    assign out_rep    = o_out_valid && (o_out_word.repeat_res != 6'd1);
    assign out_rep_ok = o_out_word.is_data && (o_out_word.value == cltw_pkg::CH_SPACE)
                        && (o_out_word.repeat_res != 6'd0);

    // A stalled output word holds
    `CLTW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_word))

    // No new item while a word of the current one is still short of its last
    `CLTW_ASSERT_IMP(a_busy_mid_item, i_clk, i_rst_n, o_out_valid && !o_out_word.last, !o_in_ready)

    // Items are taken one at a time
    `CLTW_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // Only the newline blanking run repeats, and never zero times
    `CLTW_ASSERT_IMP(a_repeat_space, i_clk, i_rst_n, out_rep, out_rep_ok)

endmodule

bind char_lcd_terminal_writer_top cltw_checker u_cltw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
